>>> hdl/mma_pkg.sv
// Shared constants for the multichannel moving average block.
// No dependencies; imported by the top level.
`default_nettype none
package mma_pkg;
  localparam int CHANNELS        = 4;
  localparam int FRAC_BITS       = 8;
  localparam int WINDOW_BITS     = 7;
  localparam int WINDOW_MAX_CODE = 127;
  localparam int TIME_BITS       = 32;
  localparam int SEQ_BITS        = 32;
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd8;
endpackage
`default_nettype wire

>>> hdl/mma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module mma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hdl/mma_div.sv
// Multi-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
// No dependencies; used by the top level.
`default_nettype none
module mma_div #(
  parameter int LANES = 4,
  parameter int DVD_W = 30,
  parameter int DVS_W = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [LANES-1:0][DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0]            divisor,
  output logic                             done,
  output logic      [LANES-1:0][DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              done_r, done_nxt;
  logic [DVS_W-1:0]                  dvs_r, dvs_nxt;
  logic [LANES-1:0][DVD_W-1:0]       quo_r, quo_nxt;
  logic [LANES-1:0][DVS_W-1:0]       rem_r, rem_nxt;
  logic [LANES-1:0][DVS_W:0]         shf;
  logic [LANES-1:0][DVS_W:0]         dif;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    for (int l = 0; l < LANES; l++) begin
      shf[l] = {rem_r[l], quo_r[l][DVD_W-1]};
      dif[l] = shf[l] - {1'b0, dvs_r};
    end
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      dvs_nxt = divisor;
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      for (int l = 0; l < LANES; l++) begin
        if (shf[l] >= {1'b0, dvs_r}) begin
          rem_nxt[l] = dif[l][DVS_W-1:0];
          quo_nxt[l] = {quo_r[l][DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = shf[l][DVS_W-1:0];
          quo_nxt[l] = {quo_r[l][DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

>>> hdl/multichannel_moving_average.sv
// Multichannel boxcar moving average: sample ring in RAM, serial window sum, serial divide.
// Each word is written to the ring, summed with the older entries of the window (n = window
// used), then divided; a new word is taken only in idle, after the last result has gone to the
// output register, paced by the ring read (one entry per cycle) and the bit-serial divider (SUM_W + 8 steps).
// Reset (rst_n, synchronous): window 8, counters cleared, sums rebuilt per word; ring undefined.
// Depends on mma_pkg, mma_ram, mma_div. A finished result waits in the output register.
`default_nettype none
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_reading_a,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_reading_b,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_reading_c,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_reading_d,
  input  wire logic        [TIME_BITS-1:0]             in_sample_time,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]      out_mean_a,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]      out_mean_b,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]      out_mean_c,
  output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]      out_mean_d,
  output logic        [SEQ_BITS-1:0]                   out_sequence_number,
  output logic        [TIME_BITS-1:0]                  out_result_time,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic        [WINDOW_BITS-1:0]           cfg_window_length
);
  localparam int MAX_N  = (MAX_WINDOW < WINDOW_MAX_CODE) ? MAX_WINDOW : WINDOW_MAX_CODE;
  localparam int NW     = $clog2(MAX_N + 1);
  localparam int FW     = $clog2(MAX_WINDOW + 1);
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_N);
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;
  localparam int RING_W = CHANNELS * SAMPLE_BITS;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ACC, S_DIV, S_OUT} state_t;

  state_t                               state_r, state_nxt;
  logic [WINDOW_BITS-1:0]               wl_r, wl_nxt;
  logic [AW-1:0]                        ws_r, ws_nxt;
  logic [FW-1:0]                        fill_r, fill_nxt;
  logic [SEQ_BITS-1:0]                  msg_r, msg_nxt;
  logic [RING_W-1:0]                    samp_r, samp_nxt;
  logic [TIME_BITS-1:0]                 time_r, time_nxt;
  logic [AW-1:0]                        slot_r, slot_nxt;
  logic [AW-1:0]                        rd_idx_r, rd_idx_nxt;
  logic [NW-1:0]                        n_r, n_nxt;
  logic [NW-1:0]                        iss_r, iss_nxt;
  logic                                 rvld_r, rvld_nxt;
  logic signed [SUM_W-1:0]              sums_r [CHANNELS];
  logic signed [SUM_W-1:0]              sums_nxt [CHANNELS];
  logic [CHANNELS-1:0]                  neg_r, neg_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [CHANNELS-1:0][MEAN_W-1:0]      mean_r, mean_nxt;
  logic [SEQ_BITS-1:0]                  seq_r, seq_nxt;
  logic [TIME_BITS-1:0]                 otime_r, otime_nxt;

  logic                                 ram_we, ram_re;
  logic [RING_W-1:0]                    ram_rdata;
  logic                                 div_start, div_done;
  logic [CHANNELS-1:0][DVD_W-1:0]       div_dvd, div_quo;
  logic [WINDOW_BITS-1:0]               wl_eff;
  logic [NW-1:0]                        eff, n_calc;
  logic [SUM_W-1:0]                     mag [CHANNELS];
  logic [DVD_W-1:0]                     sgn_quo [CHANNELS];

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] idx);
    prev_slot = (idx == '0) ? AW'(MAX_WINDOW - 1) : idx - 1'b1;
  endfunction

  mma_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (samp_r),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  mma_div #(
    .LANES (CHANNELS),
    .DVD_W (DVD_W),
    .DVS_W (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    wl_eff = (wl_r == '0) ? WINDOW_BITS'(1) : wl_r;
    eff    = (wl_eff > MAX_N) ? NW'(MAX_N) : NW'(wl_eff);
    n_calc = (fill_r < eff) ? NW'(fill_r) : eff;
    for (int c = 0; c < CHANNELS; c++) begin
      mag[c]     = sums_r[c][SUM_W-1] ? SUM_W'(-sums_r[c]) : SUM_W'(sums_r[c]);
      div_dvd[c] = {mag[c], {FRAC_BITS{1'b0}}};
      sgn_quo[c] = neg_r[c] ? -div_quo[c] : div_quo[c];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    ws_nxt        = ws_r;
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    samp_nxt      = samp_r;
    time_nxt      = time_r;
    slot_nxt      = slot_r;
    rd_idx_nxt    = rd_idx_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    rvld_nxt      = 1'b0;
    sums_nxt      = sums_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    mean_nxt      = mean_r;
    seq_nxt       = seq_r;
    otime_nxt     = otime_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      wl_nxt = cfg_window_length;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          samp_nxt  = {in_reading_d, in_reading_c, in_reading_b, in_reading_a};
          time_nxt  = in_sample_time;
          slot_nxt  = ws_r;
          ws_nxt    = (ws_r == AW'(MAX_WINDOW - 1)) ? '0 : ws_r + 1'b1;
          if (fill_r < FW'(MAX_WINDOW)) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        ram_we     = 1'b1;
        n_nxt      = n_calc;
        iss_nxt    = n_calc - 1'b1;
        rd_idx_nxt = prev_slot(slot_r);
        for (int c = 0; c < CHANNELS; c++) begin
          sums_nxt[c] = SUM_W'($signed(samp_r[c*SAMPLE_BITS +: SAMPLE_BITS]));
        end
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        if (iss_r != '0) begin
          ram_re     = 1'b1;
          rd_idx_nxt = prev_slot(rd_idx_r);
          iss_nxt    = iss_r - 1'b1;
          rvld_nxt   = 1'b1;
        end
        if (rvld_r) begin
          for (int c = 0; c < CHANNELS; c++) begin
            sums_nxt[c] = sums_r[c]
                        + SUM_W'($signed(ram_rdata[c*SAMPLE_BITS +: SAMPLE_BITS]));
          end
        end
        if (iss_r == '0 && !rvld_r) begin
          div_start = 1'b1;
          for (int c = 0; c < CHANNELS; c++) begin
            neg_nxt[c] = sums_r[c][SUM_W-1];
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          for (int c = 0; c < CHANNELS; c++) begin
            mean_nxt[c] = sgn_quo[c][MEAN_W-1:0];
          end
          seq_nxt       = msg_r;
          otime_nxt     = time_r;
          msg_nxt       = msg_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WINDOW_RESET;
      ws_r        <= '0;
      fill_r      <= '0;
      msg_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    samp_r   <= samp_nxt;
    time_r   <= time_nxt;
    slot_r   <= slot_nxt;
    rd_idx_r <= rd_idx_nxt;
    n_r      <= n_nxt;
    iss_r    <= iss_nxt;
    sums_r   <= sums_nxt;
    neg_r    <= neg_nxt;
    mean_r   <= mean_nxt;
    seq_r    <= seq_nxt;
    otime_r  <= otime_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_mean_a          = mean_r[0];
  assign out_mean_b          = mean_r[1];
  assign out_mean_c          = mean_r[2];
  assign out_mean_d          = mean_r[3];
  assign out_sequence_number = seq_r;
  assign out_result_time     = otime_r;

`ifndef ASSERT_OFF
  ap_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_LOAD))
    else $error("accepted word did not enter ring write");

  ap_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_WINDOW))
    else $error("fill count beyond ring depth");

  ap_window_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC || state_r == S_DIV) |-> (n_r != '0 && n_r <= fill_r))
    else $error("window length zero or beyond stored samples");

  ap_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result dropped while output register full");
`endif
endmodule
`default_nettype wire
